@@ rtl/core/alo_pkg.sv @@
// ============================================================================
// alo_pkg
// Shared constants and types of the audio looper with overdub.
// ============================================================================
package alo_pkg;

  // Number of samples the loop store holds.
  localparam int unsigned LOOP_DEPTH = 1048576;
  localparam int unsigned POS_W      = $clog2(LOOP_DEPTH);
  localparam int unsigned LEN_W      = POS_W + 1;
  localparam int unsigned SAMPLE_W   = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [POS_W-1:0]           pos_t;
  typedef logic [LEN_W-1:0]           len_t;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_REC  = 2'd1,
    PH_LOOP = 2'd2
  } phase_t;

endpackage

@@ rtl/core/alo_if.sv @@
// ============================================================================
// alo_in_if / alo_out_if
// Valid/ready request channels of the looper: audio in, played sample out.
// ============================================================================
interface alo_in_if;
  import alo_pkg::*;

  logic    valid;
  logic    ready;
  sample_t in_sample;
  logic    record_held;

  modport source (output valid, output in_sample, output record_held, input ready);
  modport sink   (input valid, input in_sample, input record_held, output ready);
endinterface

interface alo_out_if;
  import alo_pkg::*;

  logic    valid;
  logic    ready;
  sample_t play_sample;
  phase_t  phase;
  logic    loop_start;
  len_t    loop_length;

  modport source (output valid, output play_sample, output phase, output loop_start,
                  output loop_length, input ready);
  modport sink   (input valid, input play_sample, input phase, input loop_start,
                  input loop_length, output ready);
endinterface

@@ rtl/core/audio_loop_overdub.sv @@
// ============================================================================
// audio_loop_overdub
// Looper pedal core: record a loop, then play it back with saturating overdub.
// ============================================================================
// The block takes one request per clock while the output side is not stalled
// and returns one result per request. While waiting it idles until
// record_held goes high; the request that sees the press only arms
// recording. Recording then stores every sample until the
// button is released (that request's sample is dropped) or the store fills,
// and the count becomes the loop length. A release with nothing stored goes
// back to waiting. Looping plays one stored sample per request and, while the
// button is held, writes back the stored sample plus the input, saturated to
// 16 bits; the played value is always the one from before the overdub. The
// loop store is a single RAM with one write and one read port. Loop control
// (phase, length, position) is updated as a request is taken and the RAM read
// is issued in the same cycle; the read data arrive in the next cycle, and as
// the item leaves the read stage the overdub sum is written back and the result
// is loaded into the output register. With a one-sample loop a request reads
// the entry that the request ahead of it writes in that same cycle, so that sum
// is forwarded around the RAM. Entries are read only below the loop length, all
// of them written during recording, so the store needs no clearing after reset.
// ============================================================================
module audio_loop_overdub (
  input  logic             clk,
  input  logic             rst_n,
  alo_in_if.sink           in_ch,
  alo_out_if.source        out_ch
);
  import alo_pkg::*;

  typedef struct packed {
    sample_t sample;
    logic    held;
    phase_t  phase;
    logic    start;
    len_t    length;
    pos_t    pos;
  } s1_t;

  // Loop control registers.
  phase_t phase_r, phase_nxt;
  len_t   length_r, length_nxt;
  pos_t   pos_r, pos_nxt;

  // Request-side handshake and control decode.
  logic   in_acc;
  logic   in_ready;
  phase_t ph_seen;
  logic   rec_wen;
  logic   rd_en;
  pos_t   cur_pos;
  logic   cur_start;
  len_t   len_inc;
  len_t   pos_inc;

  // Read stage.
  logic    s1_valid_r;
  s1_t     s1_r, s1_nxt;
  logic    s1_adv;
  logic    s1_wen;
  sample_t s1_rdata;
  sample_t s1_sum;
  logic signed [SAMPLE_W:0] s1_wide;
  logic    fwd_r;
  sample_t fwd_data_r;

  // RAM ports.
  logic    ram_we;
  pos_t    ram_waddr;
  sample_t ram_wdata;
  logic [SAMPLE_W-1:0] ram_rdata;

  // Output register.
  logic    out_valid_r;
  sample_t out_sample_r;
  phase_t  out_phase_r;
  logic    out_start_r;
  len_t    out_length_r;

  // --------------------------------------------------------------------------
  // Handshake. A request moves into the read stage whenever that stage is
  // empty or hands its item on in the same cycle.
  // --------------------------------------------------------------------------
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign len_inc = length_r + len_t'(1);

  // --------------------------------------------------------------------------
  // Phase transitions, taken once per accepted request.
  // --------------------------------------------------------------------------
  always_comb begin
    phase_nxt = phase_r;
    if (in_acc) begin
      unique case (phase_r)
        PH_REC: begin
          if (in_ch.record_held) begin
            if (len_inc >= len_t'(LOOP_DEPTH)) begin
              phase_nxt = PH_LOOP;
            end
          end else if (length_r == '0) begin
            phase_nxt = PH_WAIT;
          end else begin
            phase_nxt = PH_LOOP;
          end
        end
        PH_LOOP: begin
          phase_nxt = PH_LOOP;
        end
        default: begin
          phase_nxt = in_ch.record_held ? PH_REC : PH_WAIT;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Length, position and RAM access of the accepted request.
  // --------------------------------------------------------------------------
  always_comb begin
    length_nxt = length_r;
    pos_nxt    = pos_r;
    ph_seen    = PH_WAIT;
    rec_wen    = 1'b0;
    rd_en      = 1'b0;
    cur_start  = 1'b0;
    // A position at or past the end of the loop restarts at zero.
    cur_pos    = ({1'b0, pos_r} >= length_r) ? '0 : pos_r;
    pos_inc    = {1'b0, cur_pos} + len_t'(1);
    if (in_acc) begin
      unique case (phase_r)
        PH_REC: begin
          ph_seen = PH_REC;
          if (in_ch.record_held) begin
            rec_wen    = 1'b1;
            length_nxt = len_inc;
            if (len_inc >= len_t'(LOOP_DEPTH)) begin
              length_nxt = len_t'(LOOP_DEPTH);
              pos_nxt    = '0;
            end
          end else if (length_r != '0) begin
            pos_nxt = '0;
          end
        end
        PH_LOOP: begin
          ph_seen   = PH_LOOP;
          rd_en     = 1'b1;
          cur_start = (cur_pos == '0);
          pos_nxt   = (pos_inc >= length_r) ? '0 : pos_inc[POS_W-1:0];
        end
        default: begin
          if (in_ch.record_held) begin
            length_nxt = '0;
          end
        end
      endcase
    end
  end

  always_comb begin
    s1_nxt.sample = in_ch.in_sample;
    s1_nxt.held   = in_ch.record_held;
    s1_nxt.phase  = ph_seen;
    s1_nxt.start  = cur_start;
    s1_nxt.length = length_nxt;
    s1_nxt.pos    = cur_pos;
  end

  // --------------------------------------------------------------------------
  // Read stage: pick up the stored sample and build the overdub sum. The
  // write-back happens in the cycle the item leaves this stage, so it is
  // done exactly once even under output back-pressure.
  // --------------------------------------------------------------------------
  assign s1_rdata = fwd_r ? fwd_data_r : sample_t'(ram_rdata);
  assign s1_wide  = {s1_rdata[SAMPLE_W-1], s1_rdata} +
                    {s1_r.sample[SAMPLE_W-1], s1_r.sample};

  always_comb begin
    if (s1_wide[SAMPLE_W] != s1_wide[SAMPLE_W-1]) begin
      // Overflow: clamp to the limit on the side of the true sign.
      s1_sum = s1_wide[SAMPLE_W] ? sample_t'({1'b1, {(SAMPLE_W-1){1'b0}}})
                                 : sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}});
    end else begin
      s1_sum = s1_wide[SAMPLE_W-1:0];
    end
  end

  assign s1_wen = s1_adv && (s1_r.phase == PH_LOOP) && s1_r.held;

  // Recording and overdub never overlap: a looping item is never followed by
  // a recording one, so the write port is a plain select.
  always_comb begin
    if (rec_wen) begin
      ram_we    = 1'b1;
      ram_waddr = length_r[POS_W-1:0];
      ram_wdata = in_ch.in_sample;
    end else begin
      ram_we    = s1_wen;
      ram_waddr = s1_r.pos;
      ram_wdata = s1_sum;
    end
  end

  alo_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (LOOP_DEPTH)
  ) u_loop_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (cur_pos),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      length_r    <= '0;
      pos_r       <= '0;
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      pos_r    <= pos_nxt;
      if (in_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (in_acc) begin
        // The RAM returns the old entry when read and written together.
        fwd_r <= rd_en && s1_wen && (cur_pos == s1_r.pos);
      end else if (s1_adv) begin
        // The read stage empties, so nothing is left to forward to.
        fwd_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r       <= s1_nxt;
      fwd_data_r <= s1_sum;
    end
    if (s1_adv) begin
      out_sample_r <= (s1_r.phase == PH_LOOP) ? s1_rdata : '0;
      out_phase_r  <= s1_r.phase;
      out_start_r  <= s1_r.start;
      out_length_r <= s1_r.length;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.play_sample = out_sample_r;
  assign out_ch.phase       = out_phase_r;
  assign out_ch.loop_start  = out_start_r;
  assign out_ch.loop_length = out_length_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(rec_wen && s1_wen))
    else $error("recording and overdub write the loop store together");

  a_pos_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LOOP) |-> ({1'b0, pos_r} < length_r))
    else $error("loop position outside the recorded loop");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= len_t'(LOOP_DEPTH))
    else $error("loop length exceeds the store");

  a_fwd_only_loop: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> (s1_valid_r && (s1_r.phase == PH_LOOP) && (length_r == len_t'(1))))
    else $error("forwarding outside a one-sample loop");

endmodule

@@ rtl/core/alo_ram.sv @@
// ============================================================================
// alo_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module alo_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
